// ===== src/bqlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared types and constants for the biquad low-pass filter: coefficient
// format, register indexes, sequencer states and the datapath control bundle.
// ----------------------------------------------------------------------------
package bqlp_pkg;

  // coefficients are signed fixed point, fixed 24-bit container
  localparam int COEF_WIDTH = 24;
  localparam int NUM_COEFS  = 5;
  localparam int INDEX_BITS = 3;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  // largest positive coefficient
  localparam coef_t COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};

  // register indexes on the configuration port
  typedef logic [INDEX_BITS-1:0] reg_index_t;
  localparam reg_index_t IDX_A0 = 3'd0;
  localparam reg_index_t IDX_A1 = 3'd1;
  localparam reg_index_t IDX_A2 = 3'd2;
  localparam reg_index_t IDX_B1 = 3'd3;
  localparam reg_index_t IDX_B2 = 3'd4;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_IN_A0 = 3'd0,
    MUL_X_A1  = 3'd1,
    MUL_Y_B1  = 3'd2,
    MUL_X_A2  = 3'd3,
    MUL_Y_B2  = 3'd4
  } mul_sel_t;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_OUT  = 7'b0000010,
    ST_FB1  = 7'b0000100,
    ST_FB2  = 7'b0001000,
    ST_S2A  = 7'b0010000,
    ST_S2B  = 7'b0100000,
    ST_HOLD = 7'b1000000
  } state_t;

  // per-cycle control for the datapath
  typedef struct packed {
    mul_sel_t mul_sel;
    logic     load_x;     // capture input sample
    logic     calc_out;   // round and saturate output sample
    logic     acc1_init;  // acc1 = x*a1 + delay_second
    logic     acc1_sub;   // acc1 -= b1*y
    logic     d1_write;   // commit delay_first, start acc2
    logic     d2_write;   // commit delay_second
    logic     clear;      // zero both delay states
  } ctrl_t;

endpackage

// ===== src/bqlp_datapath.sv =====
// ----------------------------------------------------------------------------
// bqlp_datapath
// Shared multiplier, accumulators and the two delay states of the biquad.
// One product per cycle goes through a product register into the adders.
// ----------------------------------------------------------------------------
module bqlp_datapath #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bqlp_pkg::ctrl_t                ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  bqlp_pkg::coef_t                coef_a0,
  input  bqlp_pkg::coef_t                coef_a1,
  input  bqlp_pkg::coef_t                coef_a2,
  input  bqlp_pkg::coef_t                coef_b1,
  input  bqlp_pkg::coef_t                coef_b2,
  output logic signed [SAMPLE_WIDTH-1:0] y
);
  import bqlp_pkg::*;

  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;  // product and state width
  localparam int SUMW  = PW + 1;
  localparam int ACC1W = PW + 2;
  localparam int ACC2W = PW + 1;
  localparam logic signed [SUMW-1:0] ROUND =
    {{(SUMW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] opa;
  coef_t                          opb;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           p;
  logic signed [PW-1:0]           d1;
  logic signed [PW-1:0]           d2;
  logic signed [ACC1W-1:0]        acc1;
  logic signed [ACC2W-1:0]        acc2;
  logic signed [SUMW-1:0]         out_sum;
  logic signed [SUMW-1:0]         out_shift;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [ACC2W-1:0]        s2_sum;
  logic signed [PW-1:0]           d1_next;
  logic signed [PW-1:0]           d2_next;

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_IN_A0: begin opa = sample_in; opb = coef_a0; end
      MUL_X_A1:  begin opa = x;         opb = coef_a1; end
      MUL_Y_B1:  begin opa = y;         opb = coef_b1; end
      MUL_X_A2:  begin opa = x;         opb = coef_a2; end
      MUL_Y_B2:  begin opa = y;         opb = coef_b2; end
      default:   begin opa = x;         opb = coef_a0; end
    endcase
  end

  assign prod = opa * opb;

  // output sample: round half up, shift out the fraction, saturate
  assign out_sum   = SUMW'(p) + SUMW'(d1) + ROUND;
  assign out_shift = out_sum >>> COEF_FRAC_BITS;

  always_comb begin
    if (out_shift[SUMW-1:SAMPLE_WIDTH-1] != {(SUMW-SAMPLE_WIDTH+1){out_shift[SUMW-1]}}) begin
      y_sat = {out_shift[SUMW-1], {(SAMPLE_WIDTH-1){~out_shift[SUMW-1]}}};
    end else begin
      y_sat = out_shift[SAMPLE_WIDTH-1:0];
    end
  end

  // saturate new delay_first
  always_comb begin
    if (acc1[ACC1W-1:PW-1] != {(ACC1W-PW+1){acc1[ACC1W-1]}}) begin
      d1_next = {acc1[ACC1W-1], {(PW-1){~acc1[ACC1W-1]}}};
    end else begin
      d1_next = acc1[PW-1:0];
    end
  end

  // saturate new delay_second
  assign s2_sum = acc2 - ACC2W'(p);

  always_comb begin
    if (s2_sum[ACC2W-1:PW-1] != {(ACC2W-PW+1){s2_sum[ACC2W-1]}}) begin
      d2_next = {s2_sum[ACC2W-1], {(PW-1){~s2_sum[ACC2W-1]}}};
    end else begin
      d2_next = s2_sum[PW-1:0];
    end
  end

  // product register and working values
  always_ff @(posedge clk) begin
    p <= prod;
    if (ctrl.load_x) begin
      x <= sample_in;
    end
    if (ctrl.calc_out) begin
      y <= y_sat;
    end
    if (ctrl.acc1_init) begin
      acc1 <= ACC1W'(p) + ACC1W'(d2);
    end else if (ctrl.acc1_sub) begin
      acc1 <= acc1 - ACC1W'(p);
    end
    if (ctrl.d1_write) begin
      acc2 <= ACC2W'(p);
    end
  end

  // delay states
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      d1 <= '0;
      d2 <= '0;
    end else begin
      if (ctrl.d1_write) begin
        d1 <= d1_next;
      end
      if (ctrl.d2_write) begin
        d2 <= d2_next;
      end
    end
  end

endmodule

// ===== src/biquad_lowpass_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Second-order IIR section, transposed direct form II, with programmable
// Q3.20 coefficients and one multiplier shared over five products per sample.
// The result enters the output register from state S2B, or from HOLD while the
// output is stalled. A new sample is taken only in IDLE, after five passes through
// the shared multiplier (the first in the accept cycle) and the commit of
// delay_second; a stalled output holds the next one.
// Reset: coefficients go to passthrough (a0 = 1.0), delay states to zero,
// output register empty. Any coefficient write also zeroes both delay states.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  bqlp_pkg::reg_index_t           cfg_index,
  input  bqlp_pkg::coef_t                cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
  import bqlp_pkg::*;

  localparam coef_t A0_RESET = (COEF_FRAC_BITS >= COEF_WIDTH - 1) ?
    COEF_MAX : coef_t'(1 << COEF_FRAC_BITS);

  state_t state;
  state_t state_next;
  ctrl_t  ctrl;
  coef_t  coef_a0;
  coef_t  coef_a1;
  coef_t  coef_a2;
  coef_t  coef_b1;
  coef_t  coef_b2;
  logic   cfg_hit;
  logic   in_xfer;
  logic   out_free;
  logic   out_load;
  logic signed [SAMPLE_WIDTH-1:0] y;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == ST_S2B) || (state == ST_HOLD)) && out_free;
  assign cfg_hit  = cfg_we && (cfg_index < reg_index_t'(NUM_COEFS));

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0 <= A0_RESET;
      coef_a1 <= '0;
      coef_a2 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_A0:  coef_a0 <= cfg_data;
        IDX_A1:  coef_a1 <= cfg_data;
        IDX_A2:  coef_a2 <= cfg_data;
        IDX_B1:  coef_b1 <= cfg_data;
        IDX_B2:  coef_b2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.mul_sel = MUL_IN_A0;
    ctrl.clear   = cfg_hit;
    unique case (state)
      ST_IDLE: begin
        ctrl.mul_sel = MUL_IN_A0;
        ctrl.load_x  = in_xfer;
        if (in_xfer) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        ctrl.mul_sel  = MUL_X_A1;
        ctrl.calc_out = 1'b1;
        state_next    = ST_FB1;
      end
      ST_FB1: begin
        ctrl.mul_sel   = MUL_Y_B1;
        ctrl.acc1_init = 1'b1;
        state_next     = ST_FB2;
      end
      ST_FB2: begin
        ctrl.mul_sel  = MUL_X_A2;
        ctrl.acc1_sub = 1'b1;
        state_next    = ST_S2A;
      end
      ST_S2A: begin
        ctrl.mul_sel  = MUL_Y_B2;
        ctrl.d1_write = 1'b1;
        state_next    = ST_S2B;
      end
      ST_S2B: begin
        ctrl.d2_write = 1'b1;
        state_next    = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register, taken on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= y;
    end
  end

  bqlp_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample_in (sample_in),
    .coef_a0   (coef_a0),
    .coef_a1   (coef_a1),
    .coef_a2   (coef_a2),
    .coef_b1   (coef_b1),
    .coef_b2   (coef_b2),
    .y         (y)
  );

endmodule
